>>> rtl/vertex_hemispherical_lighting_core_defines.svh
// Assertion helpers for the lighting core checker.
`ifndef VERTEX_HEMISPHERICAL_LIGHTING_CORE_DEFINES_SVH
`define VERTEX_HEMISPHERICAL_LIGHTING_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define VHL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define VHL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// checked at every edge, reset included
`define VHL_ASSERT_ALWAYS(label, clk, cond, msg) \
    label: assert property (@(posedge clk) (cond)) else $error(msg);

`endif

>>> rtl/vhl_pkg.sv
`default_nettype none

package vhl_pkg;

    localparam int NUM_BONES_DEF = 128;
    localparam int CFG_IDX_W     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_AMBIENT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHADE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAMBERT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SKY_R   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SKY_G   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SKY_B   = 3'd5;

    localparam logic [7:0]  AMBIENT_RST = 8'd32;
    localparam logic [7:0]  SHADE_RST   = 8'd192;
    localparam logic [15:0] LAMBERT_RST = 16'd6144;
    localparam logic [15:0] SKY_RST     = 16'd32768;

    localparam logic [16:0] AMBIENT_FLOOR = 17'd6554;
    localparam logic [15:0] LAMBERT_ONE   = 16'd4096;
    localparam logic [15:0] WHITE         = 16'd32768;

    // settings as the datapath uses them, all Q16 except lambert_r (Q4.12, >= 1.0)
    typedef struct packed {
        logic [16:0] ambient;
        logic [16:0] shade;
        logic [16:0] flat;
        logic [15:0] lambert_r;
        logic [15:0] sky_r;
        logic [15:0] sky_g;
        logic [15:0] sky_b;
    } vhl_cfg_t;

    typedef struct packed {
        logic        full;
        logic        flat;
        logic        pos;
        logic [31:0] num;
    } vhl_num_t;

    typedef struct packed {
        logic        full;
        logic        flat;
        logic        pos;
        logic [16:0] c;
    } vhl_quo_t;

    typedef struct packed {
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
    } vhl_rgb_t;

endpackage

`default_nettype wire

>>> rtl/vhl_front.sv
`default_nettype none

module vhl_front #(
    parameter int NUM_BONES = vhl_pkg::NUM_BONES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic [6:0]         bone_index,
    input  logic signed [15:0] vec_x,
    input  logic signed [15:0] vec_y,
    input  logic signed [15:0] vec_z,
    input  logic               fullbright,
    input  logic               flatshade,
    input  logic [15:0]        lambert_r,
    output logic               dn_valid,
    input  logic               dn_stall,
    output vhl_pkg::vhl_num_t  dn_data
);
    import vhl_pkg::*;

    localparam int AW = (NUM_BONES > 1) ? $clog2(NUM_BONES) : 1;
    localparam logic signed [33:0] DOT_MAX = 34'sd268435456;
    localparam logic signed [34:0] ONE_Q28 = 35'sd268435456;

    logic [47:0]   bone_mem [NUM_BONES];
    logic [AW-1:0] addr;
    logic          in_range;
    logic          accept;
    logic          en1, en2, en3, en4;

    // stage 1: captured item and table read
    logic               v1_reg;
    logic               full1_reg, flat1_reg, range1_reg;
    logic signed [15:0] nx1_reg, ny1_reg, nz1_reg;
    logic [47:0]        rd_reg;
    logic signed [15:0] lx, ly, lz;
    // stage 2: products
    logic               v2_reg;
    logic               full2_reg, flat2_reg;
    logic signed [31:0] px2_reg, py2_reg, pz2_reg;
    // stage 3: dot
    logic               v3_reg;
    logic               full3_reg, flat3_reg;
    logic signed [33:0] dot3_reg;
    logic signed [33:0] dot3_next;
    // stage 4: wrap numerator
    logic               v4_reg;
    vhl_num_t           num4_reg;
    logic signed [33:0] dot_clamp;
    logic signed [34:0] num_wide;
    vhl_num_t           num4_next;

    assign addr     = AW'(bone_index);
    assign in_range = ({25'b0, bone_index} < 32'(NUM_BONES));

    // bubbles close up: a stage may load when it is empty or moving on
    assign en4      = !v4_reg || !dn_stall;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1;
    assign accept   = in_valid && en1;

    always_ff @(posedge clk)
    begin
        if (accept && !op && in_range)
        begin
            bone_mem[addr] <= {vec_x, vec_y, vec_z};
        end
        if (accept && op)
        begin
            rd_reg <= bone_mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            // a load transfer writes the table and leaves a bubble
            if (en1) v1_reg <= in_valid && op;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    assign lx = range1_reg ? $signed(rd_reg[47:32]) : 16'sd0;
    assign ly = range1_reg ? $signed(rd_reg[31:16]) : 16'sd0;
    assign lz = range1_reg ? $signed(rd_reg[15:0])  : 16'sd0;

    assign dot3_next = 34'(px2_reg) + 34'(py2_reg) + 34'(pz2_reg);

    always_comb
    begin
        dot_clamp = (dot3_reg > DOT_MAX) ? DOT_MAX : dot3_reg;
        num_wide  = 35'(dot_clamp) + $signed({3'b0, lambert_r, 16'b0}) - ONE_Q28;
        num4_next.full = full3_reg;
        num4_next.flat = flat3_reg;
        num4_next.pos  = (num_wide > 35'sd0);
        num4_next.num  = num4_next.pos ? num_wide[31:0] : 32'd0;
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            full1_reg  <= fullbright;
            flat1_reg  <= flatshade;
            range1_reg <= in_range;
            nx1_reg    <= vec_x;
            ny1_reg    <= vec_y;
            nz1_reg    <= vec_z;
        end
        if (en2)
        begin
            full2_reg <= full1_reg;
            flat2_reg <= flat1_reg;
            px2_reg   <= nx1_reg * lx;
            py2_reg   <= ny1_reg * ly;
            pz2_reg   <= nz1_reg * lz;
        end
        if (en3)
        begin
            full3_reg <= full2_reg;
            flat3_reg <= flat2_reg;
            dot3_reg  <= dot3_next;
        end
        if (en4)
        begin
            num4_reg <= num4_next;
        end
    end

    assign dn_valid = v4_reg;
    assign dn_data  = num4_reg;

endmodule

`default_nettype wire

>>> rtl/vhl_div.sv
`default_nettype none

module vhl_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_stall,
    input  vhl_pkg::vhl_num_t up_data,
    input  logic [15:0]       divisor,
    output logic              dn_valid,
    input  logic              dn_stall,
    output vhl_pkg::vhl_quo_t dn_data
);
    import vhl_pkg::*;

    // two quotient bits per stage, 18 quotient bits in all
    localparam int STAGES = 9;

    // restoring step; remainder stays below divisor so it fits 16 bits
    function automatic logic [16:0] div_step(input logic [15:0] rem, input logic b,
                                             input logic [15:0] d);
        logic [16:0] t;
        logic [16:0] diff;
        t    = {rem, b};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d})
            return {1'b1, diff[15:0]};
        else
            return {1'b0, t[15:0]};
    endfunction

    logic        v_reg    [STAGES];
    logic        en       [STAGES];
    logic [15:0] rem_reg  [STAGES];
    logic [17:0] low_reg  [STAGES];
    logic [17:0] q_reg    [STAGES];
    logic        full_reg [STAGES];
    logic        flat_reg [STAGES];
    logic        pos_reg  [STAGES];

    assign en[STAGES-1] = !v_reg[STAGES-1] || !dn_stall;
    assign up_stall     = !en[0];

    genvar i;
    generate
        for (i = 0; i < STAGES; i++)
        begin : g_stage
            logic        v_in;
            logic [15:0] rem_in;
            logic [17:0] low_in;
            logic [17:0] q_in;
            logic        full_in, flat_in, pos_in;
            logic [16:0] step_hi, step_lo;

            if (i == 0)
            begin : g_first
                // num <= divisor * 2^16, so its top 14 bits are below the divisor
                assign v_in    = up_valid;
                assign rem_in  = {2'b0, up_data.num[31:18]};
                assign low_in  = up_data.num[17:0];
                assign q_in    = 18'd0;
                assign full_in = up_data.full;
                assign flat_in = up_data.flat;
                assign pos_in  = up_data.pos;
            end
            else
            begin : g_next
                assign v_in    = v_reg[i-1];
                assign rem_in  = rem_reg[i-1];
                assign low_in  = low_reg[i-1];
                assign q_in    = q_reg[i-1];
                assign full_in = full_reg[i-1];
                assign flat_in = flat_reg[i-1];
                assign pos_in  = pos_reg[i-1];
            end

            if (i < STAGES - 1)
            begin : g_en
                assign en[i] = !v_reg[i] || en[i+1];
            end

            assign step_hi = div_step(rem_in, low_in[17], divisor);
            assign step_lo = div_step(step_hi[15:0], low_in[16], divisor);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[i] <= 1'b0;
                end
                else if (en[i])
                begin
                    v_reg[i] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[i])
                begin
                    rem_reg[i]  <= step_lo[15:0];
                    low_reg[i]  <= {low_in[15:0], 2'b00};
                    q_reg[i]    <= {q_in[15:0], step_hi[16], step_lo[16]};
                    full_reg[i] <= full_in;
                    flat_reg[i] <= flat_in;
                    pos_reg[i]  <= pos_in;
                end
            end
        end
    endgenerate

    assign dn_valid     = v_reg[STAGES-1];
    assign dn_data.full = full_reg[STAGES-1];
    assign dn_data.flat = flat_reg[STAGES-1];
    assign dn_data.pos  = pos_reg[STAGES-1];
    // quotient is at most 65536
    assign dn_data.c    = q_reg[STAGES-1][16:0];

endmodule

`default_nettype wire

>>> rtl/vhl_back.sv
`default_nettype none

module vhl_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_stall,
    input  vhl_pkg::vhl_quo_t up_data,
    input  vhl_pkg::vhl_cfg_t cfg,
    output logic              out_valid,
    input  logic              out_stall,
    output vhl_pkg::vhl_rgb_t light
);
    import vhl_pkg::*;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    logic en1, en2, en3, en4;

    // stage 1: c * shade
    logic        v1_reg;
    logic        full1_reg, flat1_reg, pos1_reg;
    logic [33:0] prod1_reg;
    // stage 2: illum
    logic        v2_reg;
    logic        full2_reg;
    logic [16:0] illum2_reg;
    logic [34:0] round_sum;
    logic [16:0] sub;
    logic [17:0] base;
    logic signed [18:0] diff;
    logic [16:0] illum2_next;
    // stage 3: tint products
    logic        v3_reg;
    logic        full3_reg;
    logic [32:0] tr3_reg, tg3_reg, tb3_reg;
    // stage 4: output register
    logic        v4_reg;
    vhl_rgb_t    rgb4_reg;
    vhl_rgb_t    rgb4_next;

    function automatic logic [15:0] tint_sat(input logic [32:0] p);
        logic [33:0] s;
        s = {1'b0, p} + 34'd32768;
        return (s[33:16] > 18'd65535) ? 16'hFFFF : s[31:16];
    endfunction

    assign en4      = !v4_reg || !out_stall;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign up_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= up_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    always_comb
    begin
        round_sum = {1'b0, prod1_reg} + 35'd32768;
        sub       = pos1_reg ? round_sum[32:16] : 17'd0;
        if (flat1_reg)
            base = {1'b0, cfg.ambient} + {1'b0, cfg.flat};
        else
            base = {1'b0, cfg.ambient} + {1'b0, cfg.shade};
        diff = $signed({1'b0, base}) - $signed({2'b0, (flat1_reg ? 17'd0 : sub)});
        if (diff < 19'sd0)
            illum2_next = 17'd0;
        else if (diff > $signed({2'b0, ONE_Q16}))
            illum2_next = ONE_Q16;
        else
            illum2_next = diff[16:0];
    end

    always_comb
    begin
        if (full3_reg)
        begin
            rgb4_next.r = WHITE;
            rgb4_next.g = WHITE;
            rgb4_next.b = WHITE;
        end
        else
        begin
            rgb4_next.r = tint_sat(tr3_reg);
            rgb4_next.g = tint_sat(tg3_reg);
            rgb4_next.b = tint_sat(tb3_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            full1_reg <= up_data.full;
            flat1_reg <= up_data.flat;
            pos1_reg  <= up_data.pos;
            prod1_reg <= {17'd0, up_data.c} * {17'd0, cfg.shade};
        end
        if (en2)
        begin
            full2_reg  <= full1_reg;
            illum2_reg <= illum2_next;
        end
        if (en3)
        begin
            full3_reg <= full2_reg;
            tr3_reg   <= {16'd0, illum2_reg} * {17'd0, cfg.sky_r};
            tg3_reg   <= {16'd0, illum2_reg} * {17'd0, cfg.sky_g};
            tb3_reg   <= {16'd0, illum2_reg} * {17'd0, cfg.sky_b};
        end
        if (en4)
        begin
            rgb4_reg <= rgb4_next;
        end
    end

    assign out_valid = v4_reg;
    assign light     = rgb4_reg;

endmodule

`default_nettype wire

>>> rtl/vertex_hemispherical_lighting_core.sv
// Channel | Handshake              | Payload
// in      | in_valid / in_stall    | op, bone_index, vec_x/y/z, fullbright, flatshade
// out     | out_valid / out_stall  | light_r, light_g, light_b
// cfg     | cfg_write              | cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; a vertex result is registered
// through 17 stages (4 front, 9 divider at two quotient bits each, 4 back).
// A load writes the bone table at its transfer and gives no result.
// Reset clears valids and settings to defaults; the bone table is not cleared.
// A stall holds only full stages: bubbles close up before input is held off.
`default_nettype none

module vertex_hemispherical_lighting_core #(
    parameter int NUM_BONES = vhl_pkg::NUM_BONES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         op,
    input  logic [6:0]                   bone_index,
    input  logic signed [15:0]           vec_x,
    input  logic signed [15:0]           vec_y,
    input  logic signed [15:0]           vec_z,
    input  logic                         fullbright,
    input  logic                         flatshade,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [15:0]                  light_r,
    output logic [15:0]                  light_g,
    output logic [15:0]                  light_b,
    input  logic                         cfg_write,
    input  logic [vhl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                  cfg_data
);
    import vhl_pkg::*;

    logic [7:0]  ambient_level_reg;
    logic [7:0]  shade_level_reg;
    logic [15:0] lambert_factor_reg;
    logic [15:0] sky_red_reg, sky_green_reg, sky_blue_reg;

    // derived settings; items reach their use well after these settle
    logic [16:0] ambient_reg, shade_reg, flat_reg;
    logic [15:0] lambert_r_reg;
    logic [17:0] flat_y_reg;
    logic [15:0] flat_s_reg, flat_s2_reg;
    logic [37:0] flat_p_reg;
    logic [16:0] ambient_next, shade_next;
    vhl_cfg_t    cfg;

    logic        front_valid, front_stall;
    vhl_num_t    front_data;
    logic        div_valid, div_stall;
    vhl_quo_t    div_data;
    vhl_rgb_t    light;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ambient_level_reg  <= AMBIENT_RST;
            shade_level_reg    <= SHADE_RST;
            lambert_factor_reg <= LAMBERT_RST;
            sky_red_reg        <= SKY_RST;
            sky_green_reg      <= SKY_RST;
            sky_blue_reg       <= SKY_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_AMBIENT: ambient_level_reg  <= cfg_data[7:0];
                REG_SHADE:   shade_level_reg    <= cfg_data[7:0];
                REG_LAMBERT: lambert_factor_reg <= cfg_data;
                REG_SKY_R:   sky_red_reg        <= cfg_data;
                REG_SKY_G:   sky_green_reg      <= cfg_data;
                REG_SKY_B:   sky_blue_reg       <= cfg_data;
                default:     ;
            endcase
        end
    end

    // x * 65536 / 255 rounded = 257x + (x >= 128)
    always_comb
    begin
        ambient_next = {1'b0, ambient_level_reg, 8'b0} + {9'b0, ambient_level_reg}
                     + {16'b0, ambient_level_reg[7]};
        shade_next   = {1'b0, shade_level_reg, 8'b0} + {9'b0, shade_level_reg}
                     + {16'b0, shade_level_reg[7]};
    end

    // 0.8 * shade: (s*262144 + 637) / 1275 = 205s + (769s + 637) / 1275,
    // the small quotient by reciprocal 842151 / 2^30
    always_ff @(posedge clk)
    begin
        ambient_reg   <= (ambient_next < AMBIENT_FLOOR) ? AMBIENT_FLOOR : ambient_next;
        shade_reg     <= shade_next;
        lambert_r_reg <= (lambert_factor_reg < LAMBERT_ONE) ? LAMBERT_ONE : lambert_factor_reg;
        flat_y_reg    <= {10'd0, shade_level_reg} * 18'd769 + 18'd637;
        flat_s_reg    <= {8'd0, shade_level_reg} * 16'd205;
        flat_p_reg    <= {20'd0, flat_y_reg} * 38'd842151;
        flat_s2_reg   <= flat_s_reg;
        flat_reg      <= {1'b0, flat_s2_reg} + {9'd0, flat_p_reg[37:30]};
    end

    assign cfg.ambient   = ambient_reg;
    assign cfg.shade     = shade_reg;
    assign cfg.flat      = flat_reg;
    assign cfg.lambert_r = lambert_r_reg;
    assign cfg.sky_r     = sky_red_reg;
    assign cfg.sky_g     = sky_green_reg;
    assign cfg.sky_b     = sky_blue_reg;

    vhl_front #(
        .NUM_BONES (NUM_BONES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .bone_index (bone_index),
        .vec_x      (vec_x),
        .vec_y      (vec_y),
        .vec_z      (vec_z),
        .fullbright (fullbright),
        .flatshade  (flatshade),
        .lambert_r  (cfg.lambert_r),
        .dn_valid   (front_valid),
        .dn_stall   (front_stall),
        .dn_data    (front_data)
    );

    vhl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (front_valid),
        .up_stall (front_stall),
        .up_data  (front_data),
        .divisor  (cfg.lambert_r),
        .dn_valid (div_valid),
        .dn_stall (div_stall),
        .dn_data  (div_data)
    );

    vhl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (div_valid),
        .up_stall  (div_stall),
        .up_data   (div_data),
        .cfg       (cfg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .light     (light)
    );

    assign light_r = light.r;
    assign light_g = light.g;
    assign light_b = light.b;

endmodule

`default_nettype wire

>>> rtl/vhl_checker.sv
`default_nettype none
`include "vertex_hemispherical_lighting_core_defines.svh"

module vhl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] light_r,
    input logic [15:0] light_g,
    input logic [15:0] light_b
);

    // a result held by the sink keeps its valid
    `VHL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "out_valid dropped under stall")

    // and keeps its data
    `VHL_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(light_r) && $stable(light_g) && $stable(light_b), "result changed under stall")

    // input may only be held off when the output is blocked
    `VHL_ASSERT_IMPLY(a_no_false_stall, clk, rst_n, !out_valid || !out_stall, !in_stall, "input stalled with output free")

    // the pipeline comes out of reset empty; valids are unknown before the first reset edge
    `VHL_ASSERT_ALWAYS(a_reset_empty, clk, rst_n || (out_valid !== 1'b1), "result valid during reset")

endmodule

bind vertex_hemispherical_lighting_core vhl_checker u_vhl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .light_r   (light_r),
    .light_g   (light_g),
    .light_b   (light_b)
);

`default_nettype wire
